@@ sv/rgbc_pkg.sv @@
`timescale 1ns / 1ps
// rgbc_pkg: shared types and constants of the rgb 3x3 convolution clamp unit
// pixel, position and result bundle types, register indexes, reset values
// no dependencies

package rgbc_pkg;

  localparam int PIX_W = 24;
  localparam int ROW_W = 16;
  localparam int COL_W = 11;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_KERNEL_TOP = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KERNEL_MID = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KERNEL_BOT = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [23:0] KERNEL_TOP_RST = 24'h00FF00;
  localparam logic [23:0] KERNEL_MID_RST = 24'hFF04FF;
  localparam logic [23:0] KERNEL_BOT_RST = 24'h00FF00;
  localparam int FW_W = 12;
  localparam int FH_W = 16;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int CNT_W = 4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             filt;
    logic             last_col;
    logic             last_row;
  } meta_t;

  typedef struct packed {
    pix_t  main;
    pix_t  col_end;
    pix_t  row_end;
    pix_t  corner;
    meta_t meta;
  } bundle_t;

  typedef enum logic [1:0] {
    SEL_MAIN,
    SEL_COL_END,
    SEL_ROW_END,
    SEL_CORNER
  } res_sel_t;

endpackage

@@ sv/rgb_3x3_convolution_clamp_unit.sv @@
`timescale 1ns / 1ps
// rgb_3x3_convolution_clamp_unit: top level, config registers, raster position,
// request credit; instantiates rgbc_line_store, rgbc_window_filter, rgbc_result_fifo
//
// channel  dir  width  contents (low bit first)
// in_      in   24     pixel_red, pixel_green, pixel_blue
// out_     out  56     out_red, out_green, out_blue, out_row, out_col; tlast run_last,
//                      tuser frame_done
// cfg_     in   24+    write enable, register index, data
//
// one pixel request accepted per clock while result queue credit remains; a pixel gives
// 0 to 4 results, one per clock on out_ while out_tready is high; extra results at
// line ends and in the last row slow intake through the 8-bundle result queue credit
// line store memory is not cleared by reset; rst_n is synchronous, active low
// out_tready low only stops intake once the result queue credit runs out

module rgb_3x3_convolution_clamp_unit #(
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rgbc_pkg::IN_TDATA_W-1:0]       in_tdata,   // red, green, blue
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rgbc_pkg::OUT_TDATA_W-1:0]      out_tdata,  // red, green, blue, row, col
  output logic                                  out_tlast,  // run_last
  output logic                                  out_tuser,  // frame_done
  input  logic                                  cfg_wr_en,
  input  logic [rgbc_pkg::CFG_AW-1:0]           cfg_addr,
  input  logic [((3*COEF_BITS > 24) ? 3*COEF_BITS : 24)-1:0] cfg_data
);

  localparam int KW = 3 * COEF_BITS;
  localparam int XW = $clog2(MAX_WIDTH);

  logic [KW-1:0]                k_top_r, k_mid_r, k_bot_r;
  logic [rgbc_pkg::FW_W-1:0]    fw_r;
  logic [rgbc_pkg::FH_W-1:0]    fh_r;
  logic [XW-1:0]                col_count_r;
  logic [rgbc_pkg::ROW_W-1:0]   row_count_r;
  logic [rgbc_pkg::CNT_W-1:0]   credit_r;

  logic [31:0]                  w_eff;
  logic [XW-1:0]                w_last;
  logic [rgbc_pkg::ROW_W-1:0]   h_last;
  logic [XW-1:0]                x;
  logic [rgbc_pkg::ROW_W-1:0]   y;
  logic                         accept;
  rgbc_pkg::meta_t              in_meta;

  logic                         ls_v;
  rgbc_pkg::pix_t               ls_up, ls_lo, ls_pix;
  rgbc_pkg::meta_t              ls_meta;
  logic                         res_v;
  rgbc_pkg::bundle_t            res;
  logic                         push;
  logic                         drop;
  logic                         pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r <= KW'(rgbc_pkg::KERNEL_TOP_RST);
      k_mid_r <= KW'(rgbc_pkg::KERNEL_MID_RST);
      k_bot_r <= KW'(rgbc_pkg::KERNEL_BOT_RST);
      fw_r    <= rgbc_pkg::FRAME_WIDTH_RST;
      fh_r    <= rgbc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rgbc_pkg::REG_KERNEL_TOP:   k_top_r <= cfg_data[KW-1:0];
        rgbc_pkg::REG_KERNEL_MID:   k_mid_r <= cfg_data[KW-1:0];
        rgbc_pkg::REG_KERNEL_BOT:   k_bot_r <= cfg_data[KW-1:0];
        rgbc_pkg::REG_FRAME_WIDTH:  fw_r    <= cfg_data[rgbc_pkg::FW_W-1:0];
        rgbc_pkg::REG_FRAME_HEIGHT: fh_r    <= cfg_data[rgbc_pkg::FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (fw_r < 12'd3) begin
      w_eff = 32'd3;
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(fw_r);
    end
    w_last = XW'(w_eff - 32'd1);
    h_last = (fh_r < 16'd3) ? 16'd2 : fh_r - 16'd1;
    x      = (col_count_r > w_last) ? w_last : col_count_r;
    y      = (row_count_r > h_last) ? h_last : row_count_r;
  end

  assign in_tready = (credit_r < rgbc_pkg::CNT_W'(rgbc_pkg::FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  assign in_meta.row      = y;
  assign in_meta.col      = rgbc_pkg::COL_W'(x);
  assign in_meta.emit     = (y != '0) && (x != '0);
  assign in_meta.filt     = (y >= 16'd2) && (x >= XW'(2));
  assign in_meta.last_col = (x == w_last);
  assign in_meta.last_row = (y == h_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (accept) begin
      if (x == w_last) begin
        col_count_r <= '0;
        row_count_r <= (y == h_last) ? '0 : y + 16'd1;
      end else begin
        col_count_r <= x + 1'b1;
        row_count_r <= y;
      end
    end
  end

  assign push = res_v && res.meta.emit;
  assign drop = res_v && !res.meta.emit;

  // items in flight or queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + rgbc_pkg::CNT_W'(accept) - rgbc_pkg::CNT_W'(drop)
                  - rgbc_pkg::CNT_W'(pop);
    end
  end

  rgbc_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_v    (accept),
    .req_addr (x),
    .req_pix  (in_tdata),
    .req_meta (in_meta),
    .rsp_v    (ls_v),
    .rsp_up   (ls_up),
    .rsp_lo   (ls_lo),
    .rsp_pix  (ls_pix),
    .rsp_meta (ls_meta)
  );

  rgbc_window_filter #(
    .COEF_BITS (COEF_BITS)
  ) u_window_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (ls_v),
    .in_up   (ls_up),
    .in_lo   (ls_lo),
    .in_pix  (ls_pix),
    .in_meta (ls_meta),
    .k_top   (k_top_r),
    .k_mid   (k_mid_r),
    .k_bot   (k_bot_r),
    .res_v   (res_v),
    .res     (res)
  );

  rgbc_result_fifo u_result_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/rgbc_line_store.sv @@
`timescale 1ns / 1ps
// rgbc_line_store: two line buffers in one synchronous memory, read-modify-write
// each entry holds the upper and lower line pixel of one column
// depends on rgbc_pkg

module rgbc_line_store #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_v,
  input  logic [$clog2(MAX_WIDTH)-1:0] req_addr,
  input  rgbc_pkg::pix_t               req_pix,
  input  rgbc_pkg::meta_t              req_meta,
  output logic                         rsp_v,
  output rgbc_pkg::pix_t               rsp_up,
  output rgbc_pkg::pix_t               rsp_lo,
  output rgbc_pkg::pix_t               rsp_pix,
  output rgbc_pkg::meta_t              rsp_meta
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = 2 * rgbc_pkg::PIX_W;

  logic [WW-1:0]   mem_r [MAX_WIDTH];
  logic [WW-1:0]   rd_q_r;
  logic [WW-1:0]   fwd_data_r;
  logic            fwd_r;
  logic            s1_v_r;
  logic [AW-1:0]   addr_r;
  rgbc_pkg::pix_t  pix_r;
  rgbc_pkg::meta_t meta_r;
  logic [WW-1:0]   rd_word;

  assign rd_word  = fwd_r ? fwd_data_r : rd_q_r;
  assign rsp_up   = rd_word[WW-1:rgbc_pkg::PIX_W];
  assign rsp_lo   = rd_word[rgbc_pkg::PIX_W-1:0];
  assign rsp_pix  = pix_r;
  assign rsp_meta = meta_r;
  assign rsp_v    = s1_v_r;

  // read old data, write back lower line moved up and new pixel as lower
  always_ff @(posedge clk) begin
    if (req_v) begin
      rd_q_r <= mem_r[req_addr];
    end
    if (s1_v_r) begin
      mem_r[addr_r] <= {rsp_lo, pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (req_v) begin
      addr_r     <= req_addr;
      pix_r      <= req_pix;
      meta_r     <= req_meta;
      fwd_data_r <= {rsp_lo, pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= req_v;
      if (req_v) begin
        fwd_r <= s1_v_r && (req_addr == addr_r);
      end
    end
  end

endmodule

@@ sv/rgbc_window_filter.sv @@
`timescale 1ns / 1ps
// rgbc_window_filter: 3x3 window registers and pipelined multiply, sum, clamp
// stages: window shift, products, row sums, total and clamp
// depends on rgbc_pkg

module rgbc_window_filter #(
  parameter int COEF_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_v,
  input  rgbc_pkg::pix_t         in_up,
  input  rgbc_pkg::pix_t         in_lo,
  input  rgbc_pkg::pix_t         in_pix,
  input  rgbc_pkg::meta_t        in_meta,
  input  logic [3*COEF_BITS-1:0] k_top,
  input  logic [3*COEF_BITS-1:0] k_mid,
  input  logic [3*COEF_BITS-1:0] k_bot,
  output logic                   res_v,
  output rgbc_pkg::bundle_t      res
);

  localparam int KW = 3 * COEF_BITS;
  localparam int PW = COEF_BITS + 9;
  localparam int SW = PW + 2;
  localparam int TW = SW + 2;

  rgbc_pkg::pix_t  win_r [3][3];
  logic            s2_v_r;
  rgbc_pkg::meta_t s2_meta_r;

  logic [KW-1:0]               krow [3];
  logic signed [COEF_BITS-1:0] coef [3][3];
  logic signed [PW-1:0]        prod_nxt [3][3][3];

  logic signed [PW-1:0] prod_r [3][3][3];
  logic                 s3_v_r;
  rgbc_pkg::meta_t      s3_meta_r;
  rgbc_pkg::pix_t       s3_p11_r, s3_p12_r, s3_p21_r, s3_p22_r;

  logic signed [SW-1:0] rsum_nxt [3][3];
  logic signed [SW-1:0] rsum_r [3][3];
  logic                 s4_v_r;
  rgbc_pkg::meta_t      s4_meta_r;
  rgbc_pkg::pix_t       s4_p11_r, s4_p12_r, s4_p21_r, s4_p22_r;

  logic signed [TW-1:0] total [3];
  rgbc_pkg::pix_t       filt_pix;

  assign krow[0] = k_top;
  assign krow[1] = k_mid;
  assign krow[2] = k_bot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (in_v) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= in_up;
      win_r[1][2] <= in_lo;
      win_r[2][2] <= in_pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = signed'(krow[r][c*COEF_BITS +: COEF_BITS]);
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[ch][r][c] = PW'(signed'({1'b0, win_r[r][c][8*ch +: 8]})) *
                               PW'(coef[r][c]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_nxt[ch][r] = SW'(prod_r[ch][r][0]) + SW'(prod_r[ch][r][1]) +
                          SW'(prod_r[ch][r][2]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = TW'(rsum_r[ch][0]) + TW'(rsum_r[ch][1]) + TW'(rsum_r[ch][2]);
      if (total[ch][TW-1]) begin
        filt_pix[8*ch +: 8] = 8'd0;
      end else if (total[ch][TW-2:8] != '0) begin
        filt_pix[8*ch +: 8] = 8'hFF;
      end else begin
        filt_pix[8*ch +: 8] = total[ch][7:0];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_v) begin
      s2_meta_r <= in_meta;
    end
    s3_meta_r <= s2_meta_r;
    s3_p11_r  <= win_r[1][1];
    s3_p12_r  <= win_r[1][2];
    s3_p21_r  <= win_r[2][1];
    s3_p22_r  <= win_r[2][2];
    prod_r    <= prod_nxt;
    s4_meta_r <= s3_meta_r;
    s4_p11_r  <= s3_p11_r;
    s4_p12_r  <= s3_p12_r;
    s4_p21_r  <= s3_p21_r;
    s4_p22_r  <= s3_p22_r;
    rsum_r    <= rsum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= in_v;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  assign res_v       = s4_v_r;
  assign res.main    = s4_meta_r.filt ? filt_pix : s4_p11_r;
  assign res.col_end = s4_p12_r;
  assign res.row_end = s4_p21_r;
  assign res.corner  = s4_p22_r;
  assign res.meta    = s4_meta_r;

endmodule

@@ sv/rgbc_result_fifo.sv @@
`timescale 1ns / 1ps
// rgbc_result_fifo: queue of per-pixel result bundles and the result serializer
// each bundle leaves as one to four result requests
// depends on rgbc_pkg

module rgbc_result_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  rgbc_pkg::bundle_t                   push_data,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rgbc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);

  rgbc_pkg::bundle_t               entries_r [rgbc_pkg::FIFO_DEPTH];
  logic [rgbc_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [rgbc_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [rgbc_pkg::CNT_W-1:0]      count_r;
  rgbc_pkg::res_sel_t              sel_r;
  rgbc_pkg::res_sel_t              sel_nxt;
  rgbc_pkg::bundle_t               head;
  rgbc_pkg::pix_t                  pix_o;
  logic [rgbc_pkg::ROW_W-1:0]      row_o;
  logic [rgbc_pkg::COL_W-1:0]      col_o;
  logic                            last_o;
  logic                            done_o;
  logic                            hs;

  assign head       = entries_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign hs         = out_tvalid && out_tready;
  assign pop        = hs && last_o;

  always_comb begin
    pix_o   = head.main;
    row_o   = head.meta.row - 16'd1;
    col_o   = head.meta.col - 11'd1;
    done_o  = 1'b0;
    last_o  = 1'b1;
    sel_nxt = rgbc_pkg::SEL_MAIN;
    case (sel_r)
      rgbc_pkg::SEL_MAIN: begin
        if (head.meta.last_col) begin
          last_o  = 1'b0;
          sel_nxt = rgbc_pkg::SEL_COL_END;
        end else if (head.meta.last_row) begin
          last_o  = 1'b0;
          sel_nxt = rgbc_pkg::SEL_ROW_END;
        end
      end
      rgbc_pkg::SEL_COL_END: begin
        pix_o = head.col_end;
        col_o = head.meta.col;
        if (head.meta.last_row) begin
          last_o  = 1'b0;
          sel_nxt = rgbc_pkg::SEL_ROW_END;
        end
      end
      rgbc_pkg::SEL_ROW_END: begin
        pix_o = head.row_end;
        row_o = head.meta.row;
        if (head.meta.last_col) begin
          last_o  = 1'b0;
          sel_nxt = rgbc_pkg::SEL_CORNER;
        end
      end
      rgbc_pkg::SEL_CORNER: begin
        pix_o  = head.corner;
        row_o  = head.meta.row;
        col_o  = head.meta.col;
        done_o = 1'b1;
      end
      default: begin
        pix_o = head.main;
      end
    endcase
  end

  assign out_tdata = {5'd0, col_o, row_o, pix_o};
  assign out_tlast = last_o;
  assign out_tuser = done_o;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sel_r    <= rgbc_pkg::SEL_MAIN;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
      if (hs) begin
        sel_r <= last_o ? rgbc_pkg::SEL_MAIN : sel_nxt;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rgbc_pkg::CNT_W'(rgbc_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < rgbc_pkg::CNT_W'(rgbc_pkg::FIFO_DEPTH)) || pop)
    else $error("push into full result queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end not on last result of a pixel");

  assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r != rgbc_pkg::SEL_MAIN) |-> out_tvalid)
    else $error("serializer mid-bundle with empty queue");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for rgb_3x3_convolution_clamp_unit, raster pixel requests in,
// filtered pixels out, each checked against a pixel-level prediction held in a scoreboard class
// depends on rgbc_pkg and rgb_3x3_convolution_clamp_unit

module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 360;
  localparam int SETTLE_CYCLES = 16;
  localparam int LINE_DEPTH = 2048;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [rgbc_pkg::PIX_W-1:0] pix;
    logic [rgbc_pkg::ROW_W-1:0] row;
    logic [rgbc_pkg::COL_W-1:0] col;
    logic                       run_last;
    logic                       frame_done;
  } conv_result_t;

  class conv_scoreboard;
    bit [23:0] kernel_rows[3];
    bit [rgbc_pkg::FW_W-1:0] width_reg;
    bit [rgbc_pkg::FH_W-1:0] height_reg;
    bit [23:0] upper_line[LINE_DEPTH];
    bit [23:0] lower_line[LINE_DEPTH];
    bit [23:0] win[3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    conv_result_t expected_pixels[$];
    int errors;

    function new();
      kernel_rows[0] = rgbc_pkg::KERNEL_TOP_RST;
      kernel_rows[1] = rgbc_pkg::KERNEL_MID_RST;
      kernel_rows[2] = rgbc_pkg::KERNEL_BOT_RST;
      width_reg = rgbc_pkg::FRAME_WIDTH_RST;
      height_reg = rgbc_pkg::FRAME_HEIGHT_RST;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [rgbc_pkg::CFG_AW-1:0] idx, logic [23:0] val);
      case (idx)
        rgbc_pkg::REG_KERNEL_TOP: kernel_rows[0] = val;
        rgbc_pkg::REG_KERNEL_MID: kernel_rows[1] = val;
        rgbc_pkg::REG_KERNEL_BOT: kernel_rows[2] = val;
        rgbc_pkg::REG_FRAME_WIDTH: width_reg = val[rgbc_pkg::FW_W-1:0];
        rgbc_pkg::REG_FRAME_HEIGHT: height_reg = val[rgbc_pkg::FH_W-1:0];
        default: ;
      endcase
    endfunction

    function bit frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    function int coef(int r, int slot);
      bit signed [7:0] c;
      c = kernel_rows[r][slot*8 +: 8];
      return int'(c);
    endfunction

    function bit [23:0] filter_window();
      bit [23:0] res;
      int acc;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            acc += int'(win[r][c][ch*8 +: 8]) * coef(r, c);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res[ch*8 +: 8] = acc[7:0];
      end
      return res;
    endfunction

    function void note_pixel(bit [23:0] pix);
      int unsigned w, h, x, y;
      bit [23:0] up, lo, v;
      conv_result_t outs[4];
      int n;
      w = 32'(width_reg);
      if (w < 3) w = 3;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      h = 32'(height_reg);
      if (h < 3) h = 3;
      x = col_pos < w ? col_pos : w - 1;
      y = row_pos < h ? row_pos : h - 1;

      up = upper_line[x];
      lo = lower_line[x];
      upper_line[x] = lo;
      lower_line[x] = pix;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = pix;

      n = 0;
      if (y >= 1 && x >= 1) begin
        v = (y >= 2 && x >= 2) ? filter_window() : win[1][1];
        outs[n] = '{v, rgbc_pkg::ROW_W'(y - 1), rgbc_pkg::COL_W'(x - 1), 1'b0, 1'b0};
        n++;
        if (x == w - 1) begin
          outs[n] = '{win[1][2], rgbc_pkg::ROW_W'(y - 1), rgbc_pkg::COL_W'(w - 1),
                      1'b0, 1'b0};
          n++;
        end
        if (y == h - 1) begin
          outs[n] = '{win[2][1], rgbc_pkg::ROW_W'(y), rgbc_pkg::COL_W'(x - 1), 1'b0, 1'b0};
          n++;
        end
        if (y == h - 1 && x == w - 1) begin
          outs[n] = '{win[2][2], rgbc_pkg::ROW_W'(y), rgbc_pkg::COL_W'(w - 1), 1'b0, 1'b1};
          n++;
        end
        outs[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++) expected_pixels.push_back(outs[i]);
      end

      if (x == w - 1) begin
        col_pos = 0;
        row_pos = (y == h - 1) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
        row_pos = y;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic [rgbc_pkg::OUT_TDATA_W-1:0] data, logic last, logic done);
      conv_result_t want;
      logic [rgbc_pkg::ROW_W-1:0] got_row;
      logic [rgbc_pkg::COL_W-1:0] got_col;
      got_row = data[rgbc_pkg::PIX_W +: rgbc_pkg::ROW_W];
      got_col = data[rgbc_pkg::PIX_W+rgbc_pkg::ROW_W +: rgbc_pkg::COL_W];
      if (expected_pixels.size() == 0) begin
        report($sformatf("result (%0d,%0d) with nothing expected", got_row, got_col));
        return;
      end
      want = expected_pixels.pop_front();
      if (data[7:0] !== want.pix[7:0])
        report($sformatf("(%0d,%0d) red %h, expected %h", want.row, want.col,
                         data[7:0], want.pix[7:0]));
      if (data[15:8] !== want.pix[15:8])
        report($sformatf("(%0d,%0d) green %h, expected %h", want.row, want.col,
                         data[15:8], want.pix[15:8]));
      if (data[23:16] !== want.pix[23:16])
        report($sformatf("(%0d,%0d) blue %h, expected %h", want.row, want.col,
                         data[23:16], want.pix[23:16]));
      if (got_row !== want.row)
        report($sformatf("row %0d, expected %0d", got_row, want.row));
      if (got_col !== want.col)
        report($sformatf("col %0d, expected %0d", got_col, want.col));
      if (last !== want.run_last)
        report($sformatf("(%0d,%0d) run_last %b, expected %b", want.row, want.col,
                         last, want.run_last));
      if (done !== want.frame_done)
        report($sformatf("(%0d,%0d) frame_done %b, expected %b", want.row, want.col,
                         done, want.frame_done));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rgbc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;    // red, green, blue
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rgbc_pkg::OUT_TDATA_W-1:0] out_tdata;        // red, green, blue, row, col
  logic                             out_tlast;        // run_last
  logic                             out_tuser;        // frame_done
  logic                             cfg_wr_en = 1'b0;
  logic [rgbc_pkg::CFG_AW-1:0]      cfg_addr = '0;
  logic [23:0]                      cfg_data = '0;

  conv_scoreboard sb;
  bit gaps_on = 1'b1;
  int unsigned cycles = 0;
  int items_sent = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  rgb_3x3_convolution_clamp_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // result side back-pressure bursts
  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic bit [23:0] rand_pixel();
    bit [23:0] p;
    p = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 3) == 0)
      for (int ch = 0; ch < 3; ch++) p[ch*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  function automatic bit [23:0] rand_kernel();
    bit [23:0] k;
    case ($urandom_range(0, 3))
      0: k = 24'($urandom_range(0, 24'hFFFFFF));
      1: begin
        for (int s = 0; s < 3; s++) k[s*8 +: 8] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      end
      default: begin
        for (int s = 0; s < 3; s++) k[s*8 +: 8] = 8'(int'($urandom_range(0, 6)) - 3);
      end
    endcase
    return k;
  endfunction

  task automatic send_pixel(bit [23:0] pix);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // pixels at column or row 0 give no result but may still be in flight
  task automatic wait_idle();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rgbc_pkg::CFG_AW-1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic finish_frame();
    do send_pixel(rand_pixel()); while (!sb.frame_start());
  endtask

  initial begin
    bit [23:0] cross_frame[9];
    int target, w_val, h_val, weff, heff;
    sb = new();
    cross_frame = '{24'hFFFFFF, 24'h00FF00, 24'h000000, 24'h00FF00, 24'hFF00FF,
                    24'h00FF00, 24'h000000, 24'h00FF00, 24'hFFFFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // width and height below three, default kernel, center clamps high and low
    write_reg(rgbc_pkg::REG_FRAME_WIDTH, 24'd0);
    write_reg(rgbc_pkg::REG_FRAME_HEIGHT, 24'd1);
    foreach (cross_frame[i]) send_pixel(cross_frame[i]);
    stop_sending();
    wait_idle();

    // extreme coefficients, oversize width, max height, then shrink mid-frame
    write_reg(rgbc_pkg::REG_KERNEL_TOP, 24'h7F807F);
    write_reg(rgbc_pkg::REG_KERNEL_MID, 24'h017F80);
    write_reg(rgbc_pkg::REG_KERNEL_BOT, 24'hFFFFFF);
    write_reg(rgbc_pkg::REG_FRAME_WIDTH, 24'hFFF);
    write_reg(rgbc_pkg::REG_FRAME_HEIGHT, 24'hFFFF);
    repeat (4) send_pixel(rand_pixel());
    stop_sending();
    wait_idle();
    write_reg(rgbc_pkg::REG_FRAME_WIDTH, 24'd3);
    repeat (7) send_pixel(rand_pixel());
    stop_sending();
    wait_idle();
    write_reg(rgbc_pkg::REG_FRAME_HEIGHT, 24'd3);
    finish_frame();

    target = RANDOM_ITEMS;
    weff = 3;
    heff = 3;
    while (items_sent < target) begin
      if (items_sent > target - 70) gaps_on = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        stop_sending();
        wait_idle();
        if ($urandom_range(0, 1)) write_reg(rgbc_pkg::REG_KERNEL_TOP, rand_kernel());
        if ($urandom_range(0, 1)) write_reg(rgbc_pkg::REG_KERNEL_MID, rand_kernel());
        if ($urandom_range(0, 1)) write_reg(rgbc_pkg::REG_KERNEL_BOT, rand_kernel());
        w_val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        h_val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        write_reg(rgbc_pkg::REG_FRAME_WIDTH, 24'(w_val));
        write_reg(rgbc_pkg::REG_FRAME_HEIGHT, 24'(h_val));
        weff = (w_val < 3) ? 3 : w_val;
        heff = (h_val < 3) ? 3 : h_val;
      end
      if ($urandom_range(0, 3) == 0) begin
        // pause mid-frame until all results are out, maybe shrink the geometry
        repeat ($urandom_range(1, weff * heff - 2)) send_pixel(rand_pixel());
        stop_sending();
        wait_idle();
        if ($urandom_range(0, 1)) begin
          h_val = $urandom_range(0, heff);
          write_reg(rgbc_pkg::REG_FRAME_HEIGHT, 24'(h_val));
          heff = (h_val < 3) ? 3 : h_val;
        end
        if ($urandom_range(0, 1)) begin
          w_val = $urandom_range(0, weff);
          write_reg(rgbc_pkg::REG_FRAME_WIDTH, 24'(w_val));
          weff = (w_val < 3) ? 3 : w_val;
        end
      end
      finish_frame();
    end

    stop_sending();
    wait_idle();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
sv/rgbc_pkg.sv
sv/rgbc_line_store.sv
sv/rgbc_window_filter.sv
sv/rgbc_result_fifo.sv
sv/rgb_3x3_convolution_clamp_unit.sv
dv/tb.sv
